// ----- rtl/core/adsr_pkg.sv -----
`default_nettype none

package adsr_pkg;

  // Configuration register indexes.
  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t REG_NOTE_LENGTH   = 3'd0;
  localparam cfg_index_t REG_ATTACK_COUNT  = 3'd1;
  localparam cfg_index_t REG_DECAY_COUNT   = 3'd2;
  localparam cfg_index_t REG_RELEASE_COUNT = 3'd3;
  localparam cfg_index_t REG_SUSTAIN_GAIN  = 3'd4;

  // Envelope phase of the sample being processed.
  typedef enum logic [3:0] {
    PH_ATTACK  = 4'b0001,
    PH_DECAY   = 4'b0010,
    PH_RELEASE = 4'b0100,
    PH_SUSTAIN = 4'b1000
  } phase_t;

  // Sequencer states.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP1 = 9'b000000010,
    S_PREP2 = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_DIVS  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_GAIN  = 9'b001000000,
    S_SCALE = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/adsr_if.sv -----
`default_nettype none

// Input channel: one audio sample per request.
interface adsr_in_if #(
  parameter int W = 16
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// Output channel: one scaled sample per request.
interface adsr_out_if #(
  parameter int W = 16
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;
  logic                note_end;

  modport source (output valid, output sample_out, output note_end, input ready);
  modport sink (input valid, input sample_out, input note_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/adsr_mul.sv -----
`default_nettype none

// Shared signed multiplier with a registered product.
module adsr_mul #(
  parameter int AW = 25,
  parameter int BW = 18
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [AW-1:0]    a,
  input  wire logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0]      p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/adsr_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend is known to be
// below divisor * 2**QW, so the quotient fits in QW bits and the upper part
// of the dividend seeds the remainder directly.
module adsr_div #(
  parameter int DW = 24,
  parameter int QW = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DW+QW-1:0] dividend,
  input  wire logic [DW-1:0]    divisor,
  output logic [QW-1:0]         quotient,
  output logic                  done
);

  localparam int CNTW = $clog2(QW + 1);

  logic [DW-1:0]   rem;
  logic [QW-1:0]   low;
  logic [DW-1:0]   den;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  // One compare and subtract per step.
  assign trial = {rem, low[QW-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DW+QW-1:QW];
      low <= dividend[QW-1:0];
      den <= divisor;
    end else if (busy) begin
      rem      <= ge ? diff[DW-1:0] : trial[DW-1:0];
      low      <= {low[QW-2:0], 1'b0};
      quotient <= {quotient[QW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/adsr_envelope_shaper_top.sv -----
// ADSR envelope shaper: scales each sample by an attack/decay/release/sustain gain.
// A ramp phase runs the sequencer through S_PREP1, S_PREP2, S_MUL, S_DIVS, S_DIV, S_GAIN,
// S_SCALE and S_OUT; sustain goes from S_PREP2 straight to S_SCALE. The bit-serial divider dominates the ramp path.
// One sample is worked on at a time: a new request is taken only once the last result is loaded for output.
// The input is taken again while a finished result waits in the output register.
// Reset (synchronous, active high) restores the register defaults, zeroes the index.
`default_nettype none

module adsr_envelope_shaper_top #(
  parameter int COUNT_WIDTH    = 24,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire adsr_pkg::cfg_index_t cfg_index,
  input  wire logic [((COUNT_WIDTH > GAIN_FRAC_BITS) ? COUNT_WIDTH
                      : GAIN_FRAC_BITS + 1)-1:0] cfg_data,
  adsr_in_if.sink                   in_ch,
  adsr_out_if.source                out_ch
);

  import adsr_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int SW = SAMPLE_WIDTH;
  localparam int GF = GAIN_FRAC_BITS;
  localparam int MA = ((CW > SW) ? CW : SW) + 1;
  localparam int MB = GF + 2;
  localparam logic [GF:0] UNITY = (GF + 1)'(1) << GF;

  // Configuration registers.
  logic [CW-1:0] note_length;
  logic [CW-1:0] attack_count;
  logic [CW-1:0] decay_count;
  logic [CW-1:0] release_count;
  logic [GF:0]   sustain_gain;

  // Note position.
  logic [CW-1:0] sample_index;

  // Sequencer and working registers.
  state_t               state;
  phase_t               phase;
  logic signed [SW-1:0] sample;
  logic [CW-1:0]        idx;
  logic                 last;
  logic [CW:0]          ad_sum;
  logic [CW:0]          rel_start;
  logic                 rel_ok;
  logic [CW-1:0]        op_x;
  logic [GF:0]          op_m;
  logic [CW-1:0]        op_den;
  logic [GF:0]          gain;

  // Output register.
  logic                 out_valid;
  logic signed [SW-1:0] out_sample;
  logic                 out_last;

  // Shared units.
  logic                    mul_en;
  logic signed [MA-1:0]    mul_a;
  logic signed [MB-1:0]    mul_b;
  logic signed [MA+MB-1:0] prod;
  logic                    div_start;
  logic [GF-1:0]           quot;
  logic                    div_done;

  // Combinational helpers.
  logic [CW-1:0] last_pos;
  logic          beyond;
  logic [CW:0]   total;
  logic [CW+1:0] rel_diff;
  logic [GF:0]   sustain_sat;
  logic          is_att;
  logic          is_dec;
  logic          is_rel;
  logic [CW:0]   rel_off;
  logic          out_load;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      note_length   <= CW'(44100);
      attack_count  <= CW'(441);
      decay_count   <= CW'(441);
      release_count <= CW'(441);
      sustain_gain  <= (GF + 1)'(1) << (GF - 1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NOTE_LENGTH:   note_length   <= cfg_data[CW-1:0];
        REG_ATTACK_COUNT:  attack_count  <= cfg_data[CW-1:0];
        REG_DECAY_COUNT:   decay_count   <= cfg_data[CW-1:0];
        REG_RELEASE_COUNT: release_count <= cfg_data[CW-1:0];
        REG_SUSTAIN_GAIN:  sustain_gain  <= cfg_data[GF:0];
        default: ;
      endcase
    end
  end

  // First prep step: clamp the index into the note and find the window bounds.
  assign last_pos    = (note_length == '0) ? '0 : note_length - 1'b1;
  assign beyond      = sample_index >= last_pos;
  assign total       = {1'b0, last_pos} + 1'b1;
  assign rel_diff    = {1'b0, total} - {2'b00, release_count};
  assign sustain_sat = (sustain_gain > UNITY) ? UNITY : sustain_gain;

  // Second prep step: phase decision in priority order.
  assign is_att  = idx < attack_count;
  assign is_dec  = (decay_count != '0) && ({1'b0, idx} < ad_sum);
  assign is_rel  = rel_ok && ({1'b0, idx} >= rel_start);
  assign rel_off = {1'b0, idx} - rel_start;

  // Multiplier operands: ramp numerator first, final scaling later.
  always_comb begin
    if (state == S_SCALE) begin
      mul_a = {{(MA - SW){sample[SW-1]}}, sample};
      mul_b = {1'b0, gain};
    end else begin
      mul_a = {{(MA - CW){1'b0}}, op_x};
      mul_b = {1'b0, op_m};
    end
  end

  assign mul_en    = (state == S_MUL) || (state == S_SCALE);
  assign div_start = (state == S_DIVS);
  assign out_load  = (state == S_OUT) && (!out_valid || out_ch.ready);

  adsr_mul #(
    .AW(MA),
    .BW(MB)
  ) u_mul (
    .clk(clk),
    .en (mul_en),
    .a  (mul_a),
    .b  (mul_b),
    .p  (prod)
  );

  adsr_div #(
    .DW(CW),
    .QW(GF)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod[CW+GF-1:0]),
    .divisor (op_den),
    .quotient(quot),
    .done    (div_done)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_index <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) state <= S_PREP1;
        end
        S_PREP1: state <= S_PREP2;
        S_PREP2: begin
          sample_index <= last ? '0 : idx + 1'b1;
          if (is_att || is_dec || is_rel) begin
            state <= S_MUL;
          end else begin
            state <= S_SCALE;
          end
        end
        S_MUL:  state <= S_DIVS;
        S_DIVS: state <= S_DIV;
        S_DIV: begin
          if (div_done) state <= S_GAIN;
        end
        S_GAIN:  state <= S_SCALE;
        S_SCALE: state <= S_OUT;
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        sample <= in_ch.sample_in;
      end
      S_PREP1: begin
        idx       <= beyond ? last_pos : sample_index;
        last      <= beyond;
        ad_sum    <= {1'b0, attack_count} + {1'b0, decay_count};
        rel_start <= rel_diff[CW:0];
        rel_ok    <= (release_count != '0) && !rel_diff[CW+1];
      end
      S_PREP2: begin
        if (is_att) begin
          phase  <= PH_ATTACK;
          op_x   <= idx;
          op_m   <= UNITY;
          op_den <= attack_count;
        end else if (is_dec) begin
          phase  <= PH_DECAY;
          op_x   <= idx - attack_count;
          op_m   <= UNITY - sustain_sat;
          op_den <= decay_count;
        end else if (is_rel) begin
          phase  <= PH_RELEASE;
          op_x   <= rel_off[CW-1:0];
          op_m   <= UNITY;
          op_den <= release_count;
        end else begin
          phase <= PH_SUSTAIN;
          gain  <= sustain_sat;
        end
      end
      S_GAIN: begin
        // Attack rises from zero; decay and release fall from unity.
        if (phase == PH_ATTACK) begin
          gain <= {1'b0, quot};
        end else begin
          gain <= UNITY - {1'b0, quot};
        end
      end
      default: ;
    endcase
  end

  // Output register: holds one result while the next request is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= prod[GF+SW-1:GF];
      out_last   <= last;
    end
  end

  assign in_ch.ready       = (state == S_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;
  assign out_ch.note_end   = out_last;

endmodule

`default_nettype wire

// ----- sim/adsr_envelope_shaper_top_test.sv -----
`default_nettype none

module adsr_envelope_shaper_top_test;
  import adsr_pkg::*;

  localparam int COUNT_W = 24;
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W = 16;
  localparam int CFG_W = (COUNT_W > FRAC_W) ? COUNT_W : FRAC_W + 1;
  localparam logic [63:0] UNITY = 64'd1 << FRAC_W;
  localparam logic [63:0] COUNT_MASK = (64'd1 << COUNT_W) - 64'd1;
  localparam logic [CFG_W-1:0] COUNT_MAX = CFG_W'(COUNT_MASK);
  localparam logic [CFG_W-1:0] SUSTAIN_MAX = CFG_W'((64'd1 << (FRAC_W + 1)) - 64'd1);
  localparam cfg_index_t REG_SPARE = cfg_index_t'(int'(REG_SUSTAIN_GAIN) + 1);

  localparam int SCRIPT_LEN = 40;
  localparam int PASSES = 11;
  localparam int PER_PASS = 50;
  localparam int PRESSURE_PASS = 2;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = FRAC_W + 10;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       note_end;
  } scaled_t;

  typedef struct {
    bit                         is_write;
    cfg_index_t                 idx;
    logic [CFG_W-1:0]           data;
    logic signed [SAMPLE_W-1:0] sample;
    bit                         typed;
    scaled_t                    want;
  } step_t;

  typedef enum int {
    SET_SHORT,
    SET_WIDE,
    SET_FULL_SCALE,
    SET_ZERO
  } setup_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [CFG_W-1:0] cfg_data;

  adsr_in_if #(.W(SAMPLE_W)) in_ch ();
  adsr_out_if #(.W(SAMPLE_W)) out_ch ();

  adsr_envelope_shaper_top #(
    .COUNT_WIDTH(COUNT_W),
    .SAMPLE_WIDTH(SAMPLE_W),
    .GAIN_FRAC_BITS(FRAC_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  // Shadow copy of the register file and the note position.
  logic [63:0] note_len_r;
  logic [63:0] attack_r;
  logic [63:0] decay_r;
  logic [63:0] release_r;
  logic [63:0] sustain_r;
  logic [63:0] note_index;

  scaled_t scaled_fifo[$];
  int mismatch_count = 0;

  // Stimulus side flags, all changed at the falling edge.
  bit steady = 1'b0;
  bit typed_on = 1'b0;
  scaled_t typed_want;
  int pass_num = -1;
  int hold_left = 0;
  bit hold_done = 1'b0;

  step_t script[SCRIPT_LEN];

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH: %s", what);
  endtask

  // Gain for position i, phases tried in the order attack, decay, release, sustain.
  function automatic logic [63:0] envelope_gain(input logic [63:0] i, input logic [63:0] total);
    logic [63:0] s;
    s = (sustain_r > UNITY) ? UNITY : sustain_r;
    if (i < attack_r) return (i * UNITY) / attack_r;
    if (decay_r != 0 && i < attack_r + decay_r) begin
      return UNITY - ((UNITY - s) * (i - attack_r)) / decay_r;
    end
    if (release_r != 0 && release_r <= total && i >= total - release_r) begin
      return UNITY - (UNITY * (i - (total - release_r))) / release_r;
    end
    return s;
  endfunction

  // Scales one sample and advances the note position.
  function automatic scaled_t shape_sample(input logic signed [SAMPLE_W-1:0] s);
    logic [63:0] total;
    logic [63:0] i;
    logic [63:0] g;
    logic signed [63:0] wide;
    logic signed [63:0] prod;
    scaled_t r;
    total = (note_len_r == 0) ? 64'd1 : note_len_r;
    i = note_index;
    if (i > total - 1) i = total - 1;
    g = envelope_gain(i, total);
    wide = s;
    prod = (wide * $signed(g)) >>> FRAC_W;
    r.sample_out = prod[SAMPLE_W-1:0];
    r.note_end = (i == total - 1);
    note_index = r.note_end ? 64'd0 : ((i + 1) & COUNT_MASK);
    return r;
  endfunction

  // Register writes, accepted requests and results are all observed at the rising edge.
  always @(posedge clk) begin
    scaled_t want;
    scaled_t got;
    if (rst) begin
      note_len_r = 64'd44100;
      attack_r = 64'd441;
      decay_r = 64'd441;
      release_r = 64'd441;
      sustain_r = 64'd32768;
      note_index = 64'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NOTE_LENGTH: note_len_r = 64'(cfg_data[COUNT_W-1:0]);
          REG_ATTACK_COUNT: attack_r = 64'(cfg_data[COUNT_W-1:0]);
          REG_DECAY_COUNT: decay_r = 64'(cfg_data[COUNT_W-1:0]);
          REG_RELEASE_COUNT: release_r = 64'(cfg_data[COUNT_W-1:0]);
          REG_SUSTAIN_GAIN: sustain_r = 64'(cfg_data[FRAC_W:0]);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.sample_out = out_ch.sample_out;
        got.note_end = out_ch.note_end;
        if (scaled_fifo.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0b with no request waiting",
                                    got.sample_out, got.note_end));
        end else begin
          want = scaled_fifo.pop_front();
          if (got.sample_out !== want.sample_out) begin
            report_mismatch($sformatf("sample_out %0d, wanted %0d",
                                      got.sample_out, want.sample_out));
          end
          if (got.note_end !== want.note_end) begin
            report_mismatch($sformatf("note_end %0b, wanted %0b",
                                      got.note_end, want.note_end));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = shape_sample(in_ch.sample_in);
        scaled_fifo.push_back(typed_on ? typed_want : want);
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and quiet passes with no stalls.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (pass_num == PRESSURE_PASS && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 16);
    end
  end

  function automatic step_t wr(input cfg_index_t idx, input logic [CFG_W-1:0] v);
    step_t t;
    t = '{1'b1, idx, v, '0, 1'b0, '0};
    return t;
  endfunction

  function automatic step_t smp(input logic signed [SAMPLE_W-1:0] s);
    step_t t;
    t = '{1'b0, REG_NOTE_LENGTH, '0, s, 1'b0, '0};
    return t;
  endfunction

  function automatic step_t smp_is(input logic signed [SAMPLE_W-1:0] s,
                                   input logic signed [SAMPLE_W-1:0] o, input logic e);
    step_t t;
    t = '{1'b0, REG_NOTE_LENGTH, '0, s, 1'b1, '{o, e}};
    return t;
  endfunction

  // Offers one request, with a random gap before it, and returns at the falling edge
  // after it was taken. Valid stays high for a following request.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit typed,
                             input scaled_t want);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_in <= s;
    typed_on <= typed;
    typed_want <= want;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
  endtask

  // Lets every outstanding request come back before the registers change.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (scaled_fifo.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(SAMPLE_W - 1){1'b0}}};
      1: return {1'b0, {(SAMPLE_W - 1){1'b1}}};
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // One random pass: a fresh register setting, then a run of random samples.
  task automatic run_pass(input int k);
    logic [CFG_W-1:0] nl;
    logic [CFG_W-1:0] at;
    logic [CFG_W-1:0] dc;
    logic [CFG_W-1:0] rl;
    logic [CFG_W-1:0] sg;
    setup_t mode;
    settle();
    steady <= (k == 5 || k == 6);
    pass_num <= k;
    if (k == 0) mode = SET_FULL_SCALE;
    else if (k == 1) mode = SET_ZERO;
    else if ($urandom_range(0, 9) < 7) mode = SET_SHORT;
    else mode = SET_WIDE;
    case (mode)
      SET_SHORT: begin
        nl = CFG_W'($urandom_range(0, 40));
        at = CFG_W'($urandom_range(0, 12));
        dc = CFG_W'($urandom_range(0, 12));
        rl = CFG_W'($urandom_range(0, 45));
        case ($urandom_range(0, 3))
          0: sg = CFG_W'(UNITY);
          1: sg = CFG_W'($urandom) & SUSTAIN_MAX;
          default: sg = CFG_W'($urandom_range(0, int'(UNITY)));
        endcase
      end
      SET_WIDE: begin
        nl = CFG_W'($urandom) & COUNT_MAX;
        at = CFG_W'($urandom) & COUNT_MAX;
        dc = CFG_W'($urandom) & COUNT_MAX;
        rl = CFG_W'($urandom) & COUNT_MAX;
        sg = CFG_W'($urandom) & SUSTAIN_MAX;
      end
      SET_FULL_SCALE: begin
        nl = COUNT_MAX;
        at = '0;
        dc = COUNT_MAX;
        rl = COUNT_MAX;
        sg = SUSTAIN_MAX;
      end
      default: begin
        nl = '0;
        at = '0;
        dc = '0;
        rl = '0;
        sg = '0;
      end
    endcase
    write_reg(REG_NOTE_LENGTH, nl);
    write_reg(REG_ATTACK_COUNT, at);
    write_reg(REG_DECAY_COUNT, dc);
    write_reg(REG_RELEASE_COUNT, rl);
    write_reg(REG_SUSTAIN_GAIN, sg);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(cfg_index_t'($urandom_range(int'(REG_SPARE), (1 << $bits(cfg_index_t)) - 1)),
                CFG_W'($urandom));
    end
    cfg_we <= 1'b0;
    for (int n = 0; n < PER_PASS; n++) begin
      send_sample(random_sample(), 1'b0, '0);
    end
  endtask

  // Fixed ceiling on the whole run.
  initial begin
    #(64'd8_000_000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int waited;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_NOTE_LENGTH;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    out_ch.ready = 1'b0;
    typed_want = '0;

    // Directed part: power-on ramp start, unity and zero gain, the degenerate
    // note lengths, a release longer than the note, then one short full envelope.
    script = '{
      smp_is(16'sh7FFF, 16'sd0, 1'b0),
      smp_is(16'sh8000, -16'sd74, 1'b0),
      wr(REG_NOTE_LENGTH, 4),
      wr(REG_ATTACK_COUNT, 0),
      wr(REG_DECAY_COUNT, 0),
      wr(REG_RELEASE_COUNT, 0),
      wr(REG_SUSTAIN_GAIN, SUSTAIN_MAX),
      wr(REG_SPARE, COUNT_MAX),
      smp_is(16'sh7FFF, 16'sh7FFF, 1'b0),
      smp_is(16'sh8000, 16'sh8000, 1'b1),
      smp_is(16'sh5555, 16'sh5555, 1'b0),
      wr(REG_NOTE_LENGTH, 0),
      smp_is(-16'sd1, -16'sd1, 1'b1),
      smp_is(16'sd12345, 16'sd12345, 1'b1),
      wr(REG_SUSTAIN_GAIN, 0),
      smp_is(-16'sd1, 16'sd0, 1'b1),
      wr(REG_NOTE_LENGTH, 8),
      wr(REG_RELEASE_COUNT, 100),
      wr(REG_SUSTAIN_GAIN, CFG_W'(UNITY)),
      smp_is(16'sd1000, 16'sd1000, 1'b0),
      smp_is(-16'sd1000, -16'sd1000, 1'b0),
      wr(REG_NOTE_LENGTH, 16),
      wr(REG_ATTACK_COUNT, 3),
      wr(REG_DECAY_COUNT, 4),
      wr(REG_RELEASE_COUNT, 5),
      wr(REG_SUSTAIN_GAIN, 20000),
      smp(16'sh7FFF), smp(16'sh8000), smp(-16'sd1), smp(16'sd1),
      smp(16'sd12345), smp(-16'sd23456), smp(16'sh7FFF), smp(16'sh8000),
      smp(16'sd3), smp(-16'sd3), smp(16'sh4000), smp(-16'sd20000),
      smp(16'sh7FFF), smp(16'sh8000)
    };

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int n = 0; n < SCRIPT_LEN; n++) begin
      if (script[n].is_write) begin
        if (n == 0 || !script[n - 1].is_write) settle();
        write_reg(script[n].idx, script[n].data);
        if (n + 1 == SCRIPT_LEN || !script[n + 1].is_write) cfg_we <= 1'b0;
      end else begin
        send_sample(script[n].sample, script[n].typed, script[n].want);
      end
    end

    for (int k = 0; k < PASSES; k++) begin
      run_pass(k);
    end

    // Drain, with a bound, then give the pipeline time to show stray results.
    in_ch.valid <= 1'b0;
    waited = 0;
    while (scaled_fifo.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (scaled_fifo.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", scaled_fifo.size()));
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
